// ===== design/swss_pkg.sv =====
// ----------------------------------------------------------------------------
// swss_pkg
// Shared types, constants and the segment table for the serial stopwatch.
// ----------------------------------------------------------------------------
package swss_pkg;

  localparam int CmdW       = 2;
  localparam int PrescaleW  = 16;
  localparam int DotW       = 4;
  localparam int Digits     = 4;
  localparam int DigitW     = 4;
  localparam int SegW       = 7;
  localparam int BitsPerDig = 16;
  localparam int FrameW     = Digits * BitsPerDig;
  localparam int BitCntW    = $clog2(FrameW);
  localparam int ApbAddrW   = 3;
  localparam int ApbDataW   = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK    = 2'd0,
    CMD_BUTTON  = 2'd1,
    CMD_REFRESH = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_TICKS_PER_COUNT = 1'b0,
    REG_DOT_MASK        = 1'b1
  } reg_idx_e;

  // Control from the input side to the timer core.
  typedef struct packed {
    logic tick;
    logic button;
    logic level;
  } timer_ctl_t;

  // Elapsed count as BCD digits, element 0 is the thousands digit.
  typedef logic [Digits-1:0][DigitW-1:0] bcd_t;

  // Active-low segments, bit 6 = g down to bit 0 = a.
  function automatic logic [SegW-1:0] seg_code(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0:    code = 7'h40;
      4'd1:    code = 7'h79;
      4'd2:    code = 7'h24;
      4'd3:    code = 7'h30;
      4'd4:    code = 7'h19;
      4'd5:    code = 7'h12;
      4'd6:    code = 7'h02;
      4'd7:    code = 7'h78;
      4'd8:    code = 7'h00;
      4'd9:    code = 7'h10;
      default: code = 7'h7F;
    endcase
    return code;
  endfunction

endpackage

// ===== design/swss_if.sv =====
// ----------------------------------------------------------------------------
// swss_if
// Valid/ready channels for stopwatch commands and serial output bits.
// ----------------------------------------------------------------------------
interface swss_in_if;
  logic                     valid;
  logic                     ready;
  logic [swss_pkg::CmdW-1:0] cmd;
  logic                     button_level;

  modport source (output valid, cmd, button_level, input ready);
  modport sink   (input valid, cmd, button_level, output ready);
endinterface

interface swss_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch_pulse;
  logic last_bit;

  modport source (output valid, serial_bit, latch_pulse, last_bit, input ready);
  modport sink   (input valid, serial_bit, latch_pulse, last_bit, output ready);
endinterface

// ===== design/swss_timer.sv =====
// ----------------------------------------------------------------------------
// swss_timer
// Prescaler, BCD elapsed counter and run/pause button logic.
// ----------------------------------------------------------------------------
module swss_timer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swss_pkg::timer_ctl_t           ctl_i,
  input  logic [swss_pkg::PrescaleW-1:0] ticks_per_count_i,
  output swss_pkg::bcd_t                 digits_o
);
  import swss_pkg::*;

  logic [PrescaleW-1:0] prescale_q, prescale_d;
  bcd_t                 digits_q, digits_d;
  logic                 running_q, running_d;
  logic                 held_q, held_d;
  logic [PrescaleW:0]   prescale_inc;
  logic                 step;
  logic                 carry;

  assign prescale_inc = {1'b0, prescale_q} + {{PrescaleW{1'b0}}, 1'b1};
  assign step         = ctl_i.tick && running_q &&
                        (prescale_inc >= {1'b0, ticks_per_count_i});

  always_comb begin
    prescale_d = prescale_q;
    if (ctl_i.tick && running_q) begin
      prescale_d = step ? '0 : prescale_inc[PrescaleW-1:0];
    end
  end

  // BCD increment, ones digit first; 9999 rolls over to 0000.
  always_comb begin
    digits_d = digits_q;
    carry    = step;
    for (int i = Digits - 1; i >= 0; i--) begin
      if (carry) begin
        if (digits_q[i] == 4'd9) begin
          digits_d[i] = '0;
        end else begin
          digits_d[i] = digits_q[i] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
  end

  // Toggle on press edge, rearm on release.
  always_comb begin
    running_d = running_q;
    held_d    = held_q;
    if (ctl_i.button) begin
      if (!held_q && !ctl_i.level) begin
        held_d    = 1'b1;
        running_d = !running_q;
      end else if (held_q && ctl_i.level) begin
        held_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      digits_q   <= '0;
      running_q  <= 1'b1;
      held_q     <= 1'b0;
    end else begin
      prescale_q <= prescale_d;
      digits_q   <= digits_d;
      running_q  <= running_d;
      held_q     <= held_d;
    end
  end

  assign digits_o = digits_q;

endmodule

// ===== design/swss_serializer.sv =====
// ----------------------------------------------------------------------------
// swss_serializer
// Builds the 64-bit display frame and shifts it out one bit per transaction.
// ----------------------------------------------------------------------------
module swss_serializer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  swss_pkg::bcd_t            digits_i,
  input  logic [swss_pkg::DotW-1:0] dot_mask_i,
  output logic                      can_load_o,
  swss_out_if.source                out_if
);
  import swss_pkg::*;

  logic [FrameW-1:0]  shift_q, shift_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [FrameW-1:0]  frame;
  logic               out_fire;
  logic               last_beat;

  // Digit 0 (the thousands digit) goes first, first-sent bit in the MSB.
  always_comb begin
    for (int d = 0; d < Digits; d++) begin
      frame[FrameW-1-d*BitsPerDig -: BitsPerDig] =
        {dot_mask_i[d], seg_code(digits_i[d]), 8'h08 >> d};
    end
  end

  assign out_fire   = out_if.valid && out_if.ready;
  assign last_beat  = (cnt_q == BitCntW'(FrameW - 1));
  assign can_load_o = !busy_q || (out_fire && last_beat);

  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (out_fire) begin
      shift_d = {shift_q[FrameW-2:0], 1'b0};
      cnt_d   = cnt_q + BitCntW'(1);
      if (last_beat) begin
        busy_d = 1'b0;
      end
    end
    if (load_i) begin
      shift_d = frame;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign out_if.valid       = busy_q;
  assign out_if.serial_bit  = shift_q[FrameW-1];
  assign out_if.latch_pulse = (cnt_q[3:0] == 4'(BitsPerDig - 1));
  assign out_if.last_bit    = last_beat;

endmodule

// ===== design/stopwatch_serial_seven_segment.sv =====
// ----------------------------------------------------------------------------
// stopwatch_serial_seven_segment
// Four-digit stopwatch that streams seven-segment frames for a chain of two
// serial-in shift registers.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                              handshake
//   in_if     sink       cmd, button_level                    valid/ready
//   out_if    source     serial_bit, latch_pulse, last_bit    valid/ready
//   apb       slave      paddr, pwdata, prdata                psel/penable
//
// Ticks and button samples can follow back to back; they make no output
// transaction. A refresh loads the 64-bit frame and drains it one bit per
// output transaction, first bit on the next cycle. Hold a new refresh until
// the shifter sends its last bit; ticks and button samples keep flowing
// meanwhile. Reset (rst_ni low, asynchronous) clears the counters, sets the
// watch running, ticks_per_count 50, dot_mask 15.
// ----------------------------------------------------------------------------
module stopwatch_serial_seven_segment (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  swss_in_if.sink                       in_if,
  swss_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swss_pkg::ApbAddrW-1:0] paddr,
  input  logic [swss_pkg::ApbDataW-1:0] pwdata,
  output logic [swss_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import swss_pkg::*;

  logic [PrescaleW-1:0] ticks_per_count_q;
  logic [DotW-1:0]      dot_mask_q;
  logic                 cfg_wr;
  reg_idx_e             reg_idx;
  logic                 in_fire;
  logic                 can_load;
  logic                 refresh_load;
  timer_ctl_t           timer_ctl;
  bcd_t                 digits;

  // --------------------------------------------------------------------------
  // APB register file: word address selects the register
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_count_q <= PrescaleW'(50);
      dot_mask_q        <= DotW'(15);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TICKS_PER_COUNT: ticks_per_count_q <= pwdata[PrescaleW-1:0];
        REG_DOT_MASK:        dot_mask_q        <= pwdata[DotW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TICKS_PER_COUNT: prdata = {{(ApbDataW-PrescaleW){1'b0}}, ticks_per_count_q};
      REG_DOT_MASK:        prdata = {{(ApbDataW-DotW){1'b0}}, dot_mask_q};
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Command decode: only a refresh has to wait for the shifter
  // --------------------------------------------------------------------------
  assign in_if.ready  = (in_if.cmd != CMD_REFRESH) || can_load;
  assign in_fire      = in_if.valid && in_if.ready;
  assign refresh_load = in_fire && (in_if.cmd == CMD_REFRESH);

  always_comb begin
    timer_ctl        = '0;
    timer_ctl.level  = in_if.button_level;
    if (in_fire) begin
      case (in_if.cmd)
        CMD_TICK:   timer_ctl.tick   = 1'b1;
        CMD_BUTTON: timer_ctl.button = 1'b1;
        default: ;  // refresh handled by the shifter; code three is dropped
      endcase
    end
  end

  // Count state; the refresh samples it before this cycle's update.
  swss_timer u_timer (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (timer_ctl),
    .ticks_per_count_i (ticks_per_count_q),
    .digits_o          (digits)
  );

  // Frame build and bit shifter with the registered output.
  swss_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (refresh_load),
    .digits_i   (digits),
    .dot_mask_i (dot_mask_q),
    .can_load_o (can_load),
    .out_if     (out_if)
  );

endmodule

// ===== tb/sv/swss_frame_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_frame_check
// Watches the command, serial-bit and register channels of the stopwatch,
// predicts every shifted bit and compares each output transaction with it.
// ----------------------------------------------------------------------------
module swss_frame_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  swss_in_if                            cmd_if,
  swss_out_if                           bit_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [swss_pkg::ApbAddrW-1:0] paddr,
  input  logic [swss_pkg::ApbDataW-1:0] pwdata,
  output int                            errors_o,
  output int                            pending_o,
  output logic [13:0]                   elapsed_o
);
  import swss_pkg::*;

  localparam logic [13:0] COUNT_LAST  = 14'd9999;
  localparam int          REPORT_MAX  = 20;

  // Active-low segment patterns, g down to a.
  localparam logic [6:0] DIGIT_SEGS [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  typedef struct packed {
    logic serial_bit;
    logic latch_pulse;
    logic last_bit;
  } shift_bit_t;

  logic [15:0] ticks_per_count_q;
  logic [3:0]  dot_mask_q;
  logic [15:0] prescale_q;
  logic [13:0] elapsed_q;
  logic        running_q;
  logic        held_q;
  shift_bit_t  frame_bits_q[$];

  task automatic step_tick();
    logic [16:0] next_presc;
    next_presc = {1'b0, prescale_q} + 17'd1;
    if (!running_q) return;
    if (next_presc >= {1'b0, ticks_per_count_q}) begin
      prescale_q = '0;
      elapsed_q  = (elapsed_q >= COUNT_LAST) ? '0 : elapsed_q + 14'd1;
    end else begin
      prescale_q = next_presc[15:0];
    end
  endtask

  // Toggle on a press edge, rearm on release.
  task automatic sample_button(logic level);
    if (!held_q && !level) begin
      held_q    = 1'b1;
      running_q = !running_q;
    end else if (held_q && level) begin
      held_q = 1'b0;
    end
  endtask

  task automatic load_frame();
    int          digit [4];
    logic [15:0] word;
    shift_bit_t  sb;
    digit[0] = elapsed_q / 1000;
    digit[1] = (elapsed_q % 1000) / 100;
    digit[2] = (elapsed_q % 100) / 10;
    digit[3] = elapsed_q % 10;
    for (int d = 0; d < 4; d++) begin
      word = {dot_mask_q[d], DIGIT_SEGS[digit[d]], 8'h08 >> d};
      for (int b = 0; b < 16; b++) begin
        sb.serial_bit  = word[15-b];
        sb.latch_pulse = (b == 15);
        sb.last_bit    = (d == 3) && (b == 15);
        frame_bits_q.push_back(sb);
      end
    end
  endtask

  task automatic check_bit(shift_bit_t got);
    shift_bit_t want;
    if (frame_bits_q.size() == 0) begin
      errors_o++;
      if (errors_o <= REPORT_MAX)
        $display("%0t: unexpected bit, expected none, actual %b", $time, got);
      return;
    end
    want = frame_bits_q.pop_front();
    if (got.serial_bit !== want.serial_bit || got.latch_pulse !== want.latch_pulse ||
        got.last_bit !== want.last_bit) begin
      errors_o++;
      if (errors_o <= REPORT_MAX)
        $display("%0t: bit mismatch (serial/latch/last), expected %b, actual %b",
                 $time, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_count_q = 16'd50;
      dot_mask_q        = 4'd15;
      prescale_q        = '0;
      elapsed_q         = '0;
      running_q         = 1'b1;
      held_q            = 1'b0;
      frame_bits_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_TICKS_PER_COUNT: ticks_per_count_q = pwdata[15:0];
          REG_DOT_MASK:        dot_mask_q        = pwdata[3:0];
          default: ;
        endcase
      end
      if (cmd_if.valid && cmd_if.ready) begin
        case (cmd_if.cmd)
          CMD_TICK:    step_tick();
          CMD_BUTTON:  sample_button(cmd_if.button_level);
          CMD_REFRESH: load_frame();
          default: ;
        endcase
      end
      if (bit_if.valid && bit_if.ready)
        check_bit({bit_if.serial_bit, bit_if.latch_pulse, bit_if.last_bit});
    end
    pending_o = frame_bits_q.size();
    elapsed_o = elapsed_q;
  end

endmodule

// ===== tb/sv/stopwatch_serial_seven_segment_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_serial_seven_segment_tb
// Drives commands and register writes into the serial stopwatch under
// changing idle and stall patterns; the frame checker beside the block
// predicts and compares every shifted bit.
// ----------------------------------------------------------------------------
module stopwatch_serial_seven_segment_tb;
  import swss_pkg::*;

  // Command code that the block must ignore.
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam logic            PRESSED    = 1'b0;
  localparam logic            RELEASED   = 1'b1;

  // Long receiver hold-off and the quiet-cycle limit of the watchdog; the
  // limit covers the hold-off several times over.
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 100;
  localparam int SETTLE_GAP   = 4;
  localparam int TAIL_CYCLES  = 20;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int          errors;
  int          pending;
  logic [13:0] elapsed;

  // Idle and stall percentages and the hold request; stall_pct and hold_req are shared with the receiver process.
  int   idle_pct;
  int   stall_pct;
  logic hold_req;

  swss_in_if  cmd_if ();
  swss_out_if bit_if ();

  stopwatch_serial_seven_segment dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (cmd_if),
    .out_if  (bit_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swss_frame_check frame_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_if    (cmd_if),
    .bit_if    (bit_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors_o  (errors),
    .pending_o (pending),
    .elapsed_o (elapsed)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: stall at the current rate, or hold ready low for a long
  // stretch once when asked, counting the stretch here.
  initial begin : receiver
    int   hold_left;
    logic hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    bit_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req === 1'b1 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        bit_if.ready <= 1'b0;
      end else begin
        bit_if.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run when no transaction of any kind moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (bit_if.valid && bit_if.ready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one command, with a random gap first at the current idle rate.
  // Leave valid high on return so back-to-back items follow without a gap.
  task automatic send_item(logic [CmdW-1:0] cmd, logic level);
    if ($urandom_range(99, 0) < idle_pct) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.cmd          <= cmd;
    cmd_if.button_level <= level;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
  endtask

  task automatic send_random();
    int   pick;
    logic level;
    pick  = $urandom_range(99, 0);
    level = 1'($urandom_range(1, 0));
    if (pick < 50)      send_item(CMD_TICK, level);
    else if (pick < 72) send_item(CMD_BUTTON, level);
    else if (pick < 96) send_item(CMD_REFRESH, level);
    else                send_item(CMD_UNUSED, level);
  endtask

  // Drop valid and wait until every predicted bit has come out, then leave a
  // settle gap for the last tick or button sample to land.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  // Setup cycle, access cycle, then an idle step so the next write does
  // not raise psel in the same step that this one drops it.
  task automatic write_reg(reg_idx_e idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [15:0] limit, logic [3:0] mask);
    settle();
    write_reg(REG_TICKS_PER_COUNT, limit);
    write_reg(REG_DOT_MASK, {12'd0, mask});
  endtask

  initial begin : stimulus
    // Hold every input at a known value from time zero.
    rst_ni              = 1'b0;
    hold_req            = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;
    cmd_if.valid        = 1'b0;
    cmd_if.cmd          = CMD_TICK;
    cmd_if.button_level = RELEASED;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on reset settings: blank dots, reserved command, button
    // edges, a tick while paused and a second press while still held.
    send_item(CMD_REFRESH, RELEASED);
    send_item(CMD_UNUSED, PRESSED);
    send_item(CMD_BUTTON, RELEASED);   // release while not held: no effect
    send_item(CMD_TICK, RELEASED);
    send_item(CMD_BUTTON, PRESSED);    // pause
    send_item(CMD_TICK, PRESSED);      // ignored while paused
    send_item(CMD_BUTTON, PRESSED);    // still held: no effect
    send_item(CMD_BUTTON, RELEASED);
    send_item(CMD_BUTTON, PRESSED);    // run again
    send_item(CMD_BUTTON, RELEASED);
    send_item(CMD_REFRESH, PRESSED);

    // Zero limit: every running tick steps the count.
    configure(16'd0, 4'b0101);
    send_item(CMD_TICK, RELEASED);
    send_item(CMD_TICK, PRESSED);
    send_item(CMD_REFRESH, RELEASED);

    // Build the prescaler up under the widest limit, then drop the limit
    // below it so the next tick clears it.
    configure(16'hFFFF, 4'b1010);
    repeat (5) send_item(CMD_TICK, RELEASED);
    configure(16'd3, 4'b0000);
    send_item(CMD_TICK, PRESSED);
    send_item(CMD_REFRESH, PRESSED);

    // Limit of one: step the count up to 30, then alternate refreshes and ticks.
    configure(16'd1, 4'b0110);
    while (elapsed < 14'd30) send_item(CMD_TICK, 1'($urandom_range(1, 0)));
    repeat (12) begin
      send_item(CMD_REFRESH, 1'($urandom_range(1, 0)));
      send_item(CMD_TICK, 1'($urandom_range(1, 0)));
    end

    // Random part: four idle patterns, each on its own register settings.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: configure(16'd2, 4'b0000);
        1: configure(16'($urandom_range(7, 1)), 4'($urandom_range(15, 0)));
        2: configure(16'd0, 4'($urandom_range(15, 0)));
        default: configure(16'd3, 4'b1111);
      endcase
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      repeat (PHASE_ITEMS) send_random();
    end

    // Pressure: hold the receiver off while refreshes keep coming, so the
    // shifter fills and the command channel backs up.
    configure(16'd1, 4'($urandom_range(15, 0)));
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (8) begin
      send_item(CMD_REFRESH, 1'($urandom_range(1, 0)));
      send_item(CMD_TICK, 1'($urandom_range(1, 0)));
    end

    // Drain, then leave room for any stray output before the verdict.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/swss_pkg.sv
design/swss_if.sv
design/swss_timer.sv
design/swss_serializer.sv
design/stopwatch_serial_seven_segment.sv
tb/sv/swss_frame_check.sv
tb/sv/stopwatch_serial_seven_segment_tb.sv
